[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent checks sampled on the rising clock edge, masked while reset is held.
`define BCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent checks that also hold while reset is held.
`define BCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/bcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bcp_pkg;

  localparam int PRICE_WIDTH_DEF  = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_ADDR_WIDTH   = 5;

  localparam int X_LIMIT   = 805306368;
  localparam int INV_LN2_E = 24204406;
  localparam int LN2_E     = 11629080;

  localparam logic [1:0] KIND_PREMIUM = 2'd0;
  localparam logic [1:0] KIND_PRICE   = 2'd1;
  localparam logic [1:0] KIND_PAYOFF  = 2'd2;

  localparam logic [2:0] REG_PREMIUM = 3'd0;
  localparam logic [2:0] REG_START   = 3'd1;
  localparam logic [2:0] REG_STRIKE  = 3'd2;
  localparam logic [2:0] REG_BARRIER = 3'd3;
  localparam logic [2:0] REG_DRIFT   = 3'd4;
  localparam logic [2:0] REG_VOL     = 3'd5;

  typedef struct packed {
    logic [31:0]        premium;
    logic [31:0]        start_price;
    logic [31:0]        strike_price;
    logic [31:0]        barrier_level;
    logic signed [31:0] drift_step;
    logic [27:0]        vol_step;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREM,
    ST_MULZ,
    ST_K,
    ST_R,
    ST_HORN,
    ST_MUL,
    ST_SCALE,
    ST_SHIFT,
    ST_OUT
  } back_state_t;

  function automatic logic signed [31:0] taylor_coef(input logic [2:0] n);
    unique case (n)
      3'd0:    taylor_coef = 32'sd16777216;
      3'd1:    taylor_coef = 32'sd16777216;
      3'd2:    taylor_coef = 32'sd8388608;
      3'd3:    taylor_coef = 32'sd2796203;
      3'd4:    taylor_coef = 32'sd699051;
      3'd5:    taylor_coef = 32'sd139810;
      default: taylor_coef = 32'sd23302;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/bcp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface bcp_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] z;
  logic                           last_step;
  modport source(output valid, output z, output last_step, input ready);
  modport sink(input valid, input z, input last_step, output ready);
endinterface

interface bcp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  kind;
  logic        knocked_out;
  logic        path_end;
  modport source(output valid, output value, output kind, output knocked_out,
                 output path_end, input ready);
  modport sink(input valid, input value, input kind, input knocked_out,
               input path_end, output ready);
endinterface
`default_nettype wire

[rtl/bcp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcp_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0] in_z,
  input  wire logic                    in_last,
  output logic                         push_valid,
  input  wire logic                    push_ready,
  output logic [SAMPLE_WIDTH+1:0]      push_data
);

  logic started_r, started_nxt;

  // Each entry carries the sample, the final-step mark and a path-start mark.
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_data  = {in_z, in_last, ~started_r};

  always_comb begin
    started_nxt = started_r;
    if (in_valid && push_ready) begin
      started_nxt = ~in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/bcp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcp_queue
  import bcp_pkg::*;
#(
  parameter int DATA_WIDTH = 18
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire logic [DATA_WIDTH-1:0] push_data,
  output logic                       pop_valid,
  input  wire logic                  pop_ready,
  output logic [DATA_WIDTH-1:0]      pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DATA_WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]        count_r;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/bcp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcp_back
  import bcp_pkg::*;
#(
  parameter int PRICE_WIDTH  = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire logic                    pop_valid,
  output logic                         pop_ready,
  input  wire logic [SAMPLE_WIDTH+1:0] pop_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [31:0]                  out_value,
  output logic [1:0]                   out_kind,
  output logic                         out_knocked_out,
  output logic                         out_path_end
);

  localparam int W     = PRICE_WIDTH;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int NC    = (W + 31) / 32;
  localparam int CW    = (NC > 1) ? $clog2(NC) : 1;
  localparam int AW    = NC * 32 + 26;
  localparam int XW    = SW + 34;
  localparam logic [63:0]        MAXV64 = {64{1'b1}} >> (64 - W);
  localparam logic [W-1:0]       MAXV   = {W{1'b1}};
  localparam logic signed [XW-1:0] XLIM = XW'(X_LIMIT);

  back_state_t state_r, state_nxt;

  logic signed [SW-1:0] z_r;
  logic                 last_r;
  logic [W-1:0]         price_r;
  logic                 hit_r;
  logic signed [30:0]   x_r;
  logic signed [7:0]    k_r;
  logic signed [31:0]   r_r;
  logic signed [31:0]   acc_r;
  logic [2:0]           n_r;
  logic [25:0]          p_r;
  logic [CW-1:0]        c_r;
  logic [AW-1:0]        prod_r;
  logic [63:0]          m_r;
  logic                 sat_r;

  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic [1:0]  out_kind_r;
  logic        out_ko_r;
  logic        out_end_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  logic [W-1:0] start_w, strike_w, barrier_w, premium_w;
  assign start_w   = W'(cfg.start_price);
  assign strike_w  = W'(cfg.strike_price);
  assign barrier_w = W'(cfg.barrier_level);
  assign premium_w = W'(cfg.premium);

  logic signed [SW+28:0] vz;
  logic signed [XW-1:0]  xs;
  logic signed [30:0]    x_cl;
  assign vz = $signed({1'b0, cfg.vol_step}) * z_r;
  assign xs = XW'(cfg.drift_step) + XW'(vz >>> 12);
  always_comb begin
    priority if (xs > XLIM) begin
      x_cl = 31'(XLIM);
    end else if (xs < -XLIM) begin
      x_cl = 31'(-XLIM);
    end else begin
      x_cl = 31'(xs);
    end
  end

  logic signed [56:0] kp;
  assign kp = x_r * $signed(26'(INV_LN2_E));

  logic signed [33:0] kl;
  assign kl = k_r * $signed(26'(LN2_E));

  logic signed [63:0] ap;
  logic signed [31:0] acc_step;
  assign ap       = acc_r * r_r;
  assign acc_step = taylor_coef(n_r) + 32'(ap >>> 24);

  logic [NC*32-1:0] price_ext;
  logic [31:0]      chunk;
  logic [57:0]      partial;
  assign price_ext = (NC*32)'(price_r);
  assign chunk     = price_ext[c_r*32 +: 32];
  assign partial   = chunk * p_r;

  logic [AW-1:0] mf;
  logic [65:0]   m66;
  assign mf  = prod_r >> 24;
  assign m66 = 66'(mf);

  logic [6:0]  ku, nk;
  logic        ovf;
  logic [63:0] mv;
  always_comb begin
    ku  = 7'(k_r);
    nk  = 7'(-k_r);
    ovf = sat_r || (ku >= 7'd64) || (m_r > (64'hFFFF_FFFF_FFFF_FFFF >> ku));
    if (!k_r[7]) begin
      mv = (m_r != '0 && ovf) ? 64'hFFFF_FFFF_FFFF_FFFF : (m_r << ku);
    end else begin
      mv = m_r >> nk;
    end
  end

  logic         hit_now;
  logic [W-1:0] payoff;
  assign hit_now = hit_r || (price_r >= barrier_w);
  assign payoff  = (!hit_now && price_r > strike_w) ? (price_r - strike_w) : '0;

  logic emit;
  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = pop_data[0] ? ST_PREM : ST_MULZ;
        end
      end
      ST_PREM: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_MULZ;
        end
      end
      ST_MULZ:  state_nxt = ST_K;
      ST_K:     state_nxt = ST_R;
      ST_R:     state_nxt = ST_HORN;
      ST_HORN: begin
        if (n_r == 3'd0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (c_r == CW'(NC - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_PREM && emit) begin
        hit_r <= 1'b0;
      end else if (state_r == ST_OUT && emit) begin
        hit_r <= hit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        z_r    <= $signed(pop_data[SW+1:2]);
        last_r <= pop_data[1];
      end
      ST_PREM: begin
        price_r <= start_w;
      end
      ST_MULZ: begin
        x_r <= x_cl;
      end
      ST_K: begin
        k_r <= 8'(kp >>> 48);
      end
      ST_R: begin
        r_r   <= 32'(x_r) - 32'(kl);
        acc_r <= taylor_coef(3'd6);
        n_r   <= 3'd5;
      end
      ST_HORN: begin
        acc_r <= acc_step;
        n_r   <= n_r - 1'b1;
        if (n_r == 3'd0) begin
          p_r    <= (acc_step > 0) ? 26'(acc_step) : '0;
          prod_r <= '0;
          c_r    <= '0;
        end
      end
      ST_MUL: begin
        prod_r <= prod_r + (AW'(partial) << (c_r * 32));
        c_r    <= c_r + 1'b1;
      end
      ST_SCALE: begin
        sat_r <= |m66[65:64];
        m_r   <= (|m66[65:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : m66[63:0];
      end
      ST_SHIFT: begin
        price_r <= (mv > MAXV64) ? MAXV : W'(mv);
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
    if (emit) begin
      if (state_r == ST_PREM) begin
        out_value_r <= 32'(64'(premium_w));
        out_kind_r  <= KIND_PREMIUM;
        out_ko_r    <= 1'b0;
        out_end_r   <= 1'b0;
      end else if (last_r) begin
        out_value_r <= 32'(64'(payoff));
        out_kind_r  <= KIND_PAYOFF;
        out_ko_r    <= hit_now;
        out_end_r   <= 1'b1;
      end else begin
        out_value_r <= 32'(64'(price_r));
        out_kind_r  <= KIND_PRICE;
        out_ko_r    <= hit_now;
        out_end_r   <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_kind        = out_kind_r;
  assign out_knocked_out = out_ko_r;
  assign out_path_end    = out_end_r;

endmodule
`default_nettype wire

[rtl/barrier_call_path_step.sv]
// The input transfer is queued, then the shared back-end sequencer runs the sample product,
// exponent split, six Horner multiplies and the price multiply, and takes a new item only
// after the result of the last one is emitted; an item that opens a path first emits the
// premium. Wider prices add one multiply step per extra 32-bit price chunk.
// Reset is synchronous, active low: config returns to defaults and the next item opens a path.
`timescale 1ns / 1ps
`default_nettype none
module barrier_call_path_step
  import bcp_pkg::*;
#(
  parameter int PRICE_WIDTH  = PRICE_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bcp_in_if.sink                         in_ch,
  bcp_out_if.source                      out_ch,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_WIDTH-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.premium       <= 32'd0;
      cfg_r.start_price   <= 32'd65536;
      cfg_r.strike_price  <= 32'd65536;
      cfg_r.barrier_level <= 32'hFFFF_FFFF;
      cfg_r.drift_step    <= 32'sd0;
      cfg_r.vol_step      <= 28'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PREMIUM: cfg_r.premium       <= cfg_pwdata;
        REG_START:   cfg_r.start_price   <= cfg_pwdata;
        REG_STRIKE:  cfg_r.strike_price  <= cfg_pwdata;
        REG_BARRIER: cfg_r.barrier_level <= cfg_pwdata;
        REG_DRIFT:   cfg_r.drift_step    <= $signed(cfg_pwdata);
        REG_VOL:     cfg_r.vol_step      <= cfg_pwdata[27:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PREMIUM: cfg_prdata = cfg_r.premium;
      REG_START:   cfg_prdata = cfg_r.start_price;
      REG_STRIKE:  cfg_prdata = cfg_r.strike_price;
      REG_BARRIER: cfg_prdata = cfg_r.barrier_level;
      REG_DRIFT:   cfg_prdata = cfg_r.drift_step;
      REG_VOL:     cfg_prdata = {4'd0, cfg_r.vol_step};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  logic                    push_valid, push_ready, pop_valid, pop_ready;
  logic [SAMPLE_WIDTH+1:0] push_data, pop_data;

  bcp_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_z       (in_ch.z),
    .in_last    (in_ch.last_step),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bcp_queue #(
    .DATA_WIDTH(SAMPLE_WIDTH + 2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bcp_back #(
    .PRICE_WIDTH (PRICE_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_value       (out_ch.value),
    .out_kind        (out_ch.kind),
    .out_knocked_out (out_ch.knocked_out),
    .out_path_end    (out_ch.path_end)
  );

endmodule
`default_nettype wire

[rtl/bcp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bcp_checker
  import bcp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic       out_knocked_out,
  input wire logic       out_path_end
);

  `BCP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BCP_ASSERT_ALWAYS(a_end_is_payoff, !rst_n || !out_valid || !out_path_end || out_kind == KIND_PAYOFF, "path end on a non-payoff result")
  `BCP_ASSERT(a_payoff_ends, out_valid && out_kind == KIND_PAYOFF |-> out_path_end, "payoff without path end")
  `BCP_ASSERT(a_premium_clean, out_valid && out_kind == KIND_PREMIUM |-> !out_knocked_out && !out_path_end, "premium carries path flags")

endmodule

bind barrier_call_path_step bcp_checker u_bcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_knocked_out (out_ch.knocked_out),
  .out_path_end    (out_ch.path_end)
);
`default_nettype wire
